[rtl/p2dz_pkg.sv]
`timescale 1ns / 1ps

package p2dz_pkg;

  localparam int DEFAULT_MAX_WIDTH = 4096;

  localparam int CHAN_W         = 8;
  localparam int HIGH_W         = 2;
  localparam int IMAGE_WIDTH_W  = 13;
  localparam int IMAGE_HEIGHT_W = 16;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 16;

  localparam logic [IMAGE_WIDTH_W-1:0]  RESET_IMAGE_WIDTH  = 13'd4096;
  localparam logic [IMAGE_HEIGHT_W-1:0] RESET_IMAGE_HEIGHT = 16'd1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] low_red;
    logic [CHAN_W-1:0] low_green;
    logic [CHAN_W-1:0] low_blue;
    logic [HIGH_W-1:0] high_red;
    logic [HIGH_W-1:0] high_green;
    logic [HIGH_W-1:0] high_blue;
  } result_t;

endpackage

[rtl/pixel_2d_difference_zigzag.sv]
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// in        in_valid / in_ready   in_red, in_green, in_blue
// out       out_valid / out_ready out_low_*, out_high_* (red, green, blue)
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One pixel per clock unless the output stalls; pixels go through the first
// stage and the output register. The line store is read on accept, written
// as the pixel leaves stage one; a one-pixel row reads the pixel in flight.
// Synchronous active-low reset clears counters, neighbor registers and valids;
// the line store is not cleared. A stalled output holds the pipeline and
// drops in_ready; cfg_ready is always high.
module pixel_2d_difference_zigzag #(
  parameter int MAX_WIDTH = p2dz_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [p2dz_pkg::CHAN_W-1:0]          in_red,
  input  logic [p2dz_pkg::CHAN_W-1:0]          in_green,
  input  logic [p2dz_pkg::CHAN_W-1:0]          in_blue,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [p2dz_pkg::CHAN_W-1:0]          out_low_red,
  output logic [p2dz_pkg::CHAN_W-1:0]          out_low_green,
  output logic [p2dz_pkg::CHAN_W-1:0]          out_low_blue,
  output logic [p2dz_pkg::HIGH_W-1:0]          out_high_red,
  output logic [p2dz_pkg::HIGH_W-1:0]          out_high_green,
  output logic [p2dz_pkg::HIGH_W-1:0]          out_high_blue,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [p2dz_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [p2dz_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import p2dz_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = 18;
  localparam int ROW_CMP_W = IMAGE_HEIGHT_W + 1;

  logic [IMAGE_WIDTH_W-1:0]  width_r;
  logic [IMAGE_HEIGHT_W-1:0] height_r;

  logic [COL_W-1:0]          col_r, col_nxt;
  logic [IMAGE_HEIGHT_W-1:0] row_r, row_nxt;

  logic        s1_valid_r;
  pixel_t      s1_cur_r;
  logic [COL_W-1:0] s1_col_r;
  logic        s1_has_up_r;
  logic        s1_has_left_r;
  logic        fwd_r;
  pixel_t      fwd_pix_r;

  pixel_t      left_r;
  pixel_t      upper_left_r;

  logic        out_valid_r;
  result_t     out_r;

  logic        in_acc;
  logic        s1_adv;
  logic        fwd_nxt;
  pixel_t      in_pix;
  pixel_t      rd_data;
  pixel_t      stored;
  pixel_t      up_sel;
  pixel_t      left_sel;
  pixel_t      ul_sel;
  result_t     result;

  logic [CMP_W-1:0]     w_eff;
  logic [CMP_W-1:0]     col_inc;
  logic                 col_wrap;
  logic [ROW_CMP_W-1:0] h_eff;
  logic [ROW_CMP_W-1:0] row_inc;

  assign in_pix = {in_red, in_green, in_blue};

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Position of the next pixel in the frame.
  always_comb begin
    if (width_r == '0) begin
      w_eff = CMP_W'(1);
    end else if (CMP_W'(width_r) > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end else begin
      w_eff = CMP_W'(width_r);
    end
    h_eff    = (height_r == '0) ? ROW_CMP_W'(1) : ROW_CMP_W'(height_r);
    col_inc  = CMP_W'(col_r) + CMP_W'(1);
    row_inc  = ROW_CMP_W'(row_r) + ROW_CMP_W'(1);
    col_wrap = col_inc >= w_eff;
    col_nxt  = col_wrap ? '0 : col_inc[COL_W-1:0];
    if (!col_wrap) begin
      row_nxt = row_r;
    end else if (row_inc >= h_eff) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_inc[IMAGE_HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_IMAGE_WIDTH;
      height_r <= RESET_IMAGE_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[IMAGE_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[IMAGE_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // The pixel leaving the first stage writes the entry the new one reads
  // only when both sit at the same column, which needs a one-pixel row.
  assign fwd_nxt = s1_adv && (s1_col_r == col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cur_r      <= in_pix;
      s1_col_r      <= col_r;
      s1_has_up_r   <= row_r != '0;
      s1_has_left_r <= col_r != '0;
      fwd_r         <= fwd_nxt;
      fwd_pix_r     <= s1_cur_r;
    end
  end

  p2dz_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (s1_cur_r)
  );

  always_comb begin
    stored   = fwd_r ? fwd_pix_r : rd_data;
    up_sel   = s1_has_up_r ? stored : '0;
    left_sel = s1_has_left_r ? left_r : '0;
    ul_sel   = (s1_has_up_r && s1_has_left_r) ? upper_left_r : '0;
  end

  p2dz_diff u_diff (
    .cur        (s1_cur_r),
    .up         (up_sel),
    .left       (left_sel),
    .upper_left (ul_sel),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r       <= '0;
      upper_left_r <= '0;
    end else if (s1_adv) begin
      left_r       <= s1_cur_r;
      upper_left_r <= stored;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_low_red    = out_r.low_red;
  assign out_low_green  = out_r.low_green;
  assign out_low_blue   = out_r.low_blue;
  assign out_high_red   = out_r.high_red;
  assign out_high_green = out_r.high_green;
  assign out_high_blue  = out_r.high_blue;

  // Forwarding only ever happens at column zero.
  a_fwd_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && fwd_r |-> s1_col_r == '0)
    else $error("forwarded line store read away from column zero");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted item did not reach the first stage");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced item did not reach the output register");

  a_row_only_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !col_wrap |=> $stable(row_r))
    else $error("row counter moved without a column wrap");

endmodule

[rtl/p2dz_line_store.sv]
`timescale 1ns / 1ps

module p2dz_line_store #(
  parameter int DEPTH = p2dz_pkg::DEFAULT_MAX_WIDTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output p2dz_pkg::pixel_t   rd_data,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  p2dz_pkg::pixel_t   wr_data
);
  import p2dz_pkg::*;

  pixel_t store_r [DEPTH];
  pixel_t rd_data_r;

  // Read-before-write: a read and a write of the same entry in one cycle
  // returns the old contents; the caller forwards around that case.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= store_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/p2dz_diff.sv]
`timescale 1ns / 1ps

module p2dz_diff (
  input  p2dz_pkg::pixel_t  cur,
  input  p2dz_pkg::pixel_t  up,
  input  p2dz_pkg::pixel_t  left,
  input  p2dz_pkg::pixel_t  upper_left,
  output p2dz_pkg::result_t result
);
  import p2dz_pkg::*;

  localparam int DIFF_W = CHAN_W + 3;
  localparam int ZZ_W   = CHAN_W + HIGH_W;

  // The difference spans -510..510, so eleven bits hold it in two's
  // complement; zigzag is then a shift and an xor with the sign.
  function automatic logic [ZZ_W-1:0] zigzag(input logic [CHAN_W-1:0] c,
                                             input logic [CHAN_W-1:0] u,
                                             input logic [CHAN_W-1:0] l,
                                             input logic [CHAN_W-1:0] ul);
    logic [DIFF_W-1:0] d;
    logic [DIFF_W-1:0] z;
    d = DIFF_W'(c) - DIFF_W'(u) - DIFF_W'(l) + DIFF_W'(ul);
    z = {d[DIFF_W-2:0], 1'b0} ^ {DIFF_W{d[DIFF_W-1]}};
    return z[ZZ_W-1:0];
  endfunction

  logic [ZZ_W-1:0] z_red;
  logic [ZZ_W-1:0] z_green;
  logic [ZZ_W-1:0] z_blue;

  always_comb begin
    z_red   = zigzag(cur.red,   up.red,   left.red,   upper_left.red);
    z_green = zigzag(cur.green, up.green, left.green, upper_left.green);
    z_blue  = zigzag(cur.blue,  up.blue,  left.blue,  upper_left.blue);
    result.low_red    = z_red[CHAN_W-1:0];
    result.low_green  = z_green[CHAN_W-1:0];
    result.low_blue   = z_blue[CHAN_W-1:0];
    result.high_red   = z_red[ZZ_W-1:CHAN_W];
    result.high_green = z_green[ZZ_W-1:CHAN_W];
    result.high_blue  = z_blue[ZZ_W-1:CHAN_W];
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import p2dz_pkg::*;

  localparam int MAX_W = DEFAULT_MAX_WIDTH;
  localparam int CYCLE_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [CHAN_W-1:0] in_red, in_green, in_blue;
  logic out_valid;
  logic out_ready;
  logic [CHAN_W-1:0] out_low_red, out_low_green, out_low_blue;
  logic [HIGH_W-1:0] out_high_red, out_high_green, out_high_blue;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pixel_2d_difference_zigzag DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_red(in_red),
    .in_green(in_green),
    .in_blue(in_blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_low_red(out_low_red),
    .out_low_green(out_low_green),
    .out_low_blue(out_low_blue),
    .out_high_red(out_high_red),
    .out_high_green(out_high_green),
    .out_high_blue(out_high_blue),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter state as the block should hold it.
  pixel_t line_store [MAX_W];
  pixel_t left_px = '0;
  pixel_t upleft_px = '0;
  int col_pos = 0;
  int row_pos = 0;
  int store_filled = 0;
  logic [IMAGE_WIDTH_W-1:0] cur_width = RESET_IMAGE_WIDTH;
  logic [IMAGE_HEIGHT_W-1:0] cur_height = RESET_IMAGE_HEIGHT;

  result_t expected_results[$];
  int mismatches = 0;
  int items_sent = 0;
  int cycle_count = 0;
  bit idling = 1'b1;
  int hold_cycles = 0;

  function automatic int effective_width(input int w);
    return (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
  endfunction

  function automatic logic [9:0] zigzag_code(input logic [7:0] cur, input logic [7:0] above,
                                             input logic [7:0] lft, input logic [7:0] diag);
    int d;
    d = int'(cur) - int'(above) - int'(lft) + int'(diag);
    return (d >= 0) ? 10'(2 * d) : 10'(-2 * d - 1);
  endfunction

  function automatic result_t filter_pixel(input pixel_t px);
    result_t r;
    int eff_w, eff_h, c;
    pixel_t stored, up, lf, ul;
    logic [9:0] zr, zg, zb;
    eff_w = effective_width(int'(cur_width));
    eff_h = (cur_height == 0) ? 1 : int'(cur_height);
    c = col_pos % MAX_W;
    stored = line_store[c];
    up = (row_pos > 0) ? stored : '0;
    lf = (c > 0) ? left_px : '0;
    ul = (row_pos > 0 && c > 0) ? upleft_px : '0;
    zr = zigzag_code(px.red, up.red, lf.red, ul.red);
    zg = zigzag_code(px.green, up.green, lf.green, ul.green);
    zb = zigzag_code(px.blue, up.blue, lf.blue, ul.blue);
    r.low_red = zr[7:0];
    r.low_green = zg[7:0];
    r.low_blue = zb[7:0];
    r.high_red = zr[9:8];
    r.high_green = zg[9:8];
    r.high_blue = zb[9:8];
    upleft_px = stored;
    line_store[c] = px;
    left_px = px;
    if (c + 1 > store_filled) store_filled = c + 1;
    if (c + 1 >= eff_w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= eff_h) ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    return {rand_sample(), rand_sample(), rand_sample()};
  endfunction

  task automatic input_idle();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // The caller must call again right away or go idle, since valid stays up
  // after the item is taken until the next falling edge.
  task automatic send_pixel(input pixel_t px);
    int gap;
    @(negedge clk);
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      {in_red, in_green, in_blue} <= 24'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red <= px.red;
    in_green <= px.green;
    in_blue <= px.blue;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(filter_pixel(px));
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    input_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_IMAGE_WIDTH) cur_width = value[IMAGE_WIDTH_W-1:0];
    else cur_height = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A one-pixel frame pulls the counters back to the top left corner.
  task automatic start_frame();
    if (col_pos != 0 || row_pos != 0) begin
      write_reg(REG_IMAGE_WIDTH, 16'd1);
      write_reg(REG_IMAGE_HEIGHT, 16'd1);
      send_pixel(rand_pixel());
    end
  endtask

  task automatic test_reset_defaults();
    send_pixel({8'd255, 8'd0, 8'd128});
    send_pixel({8'd0, 8'd255, 8'd1});
  endtask

  // Differences of +510 and -510 on red and green, and of -510 on blue.
  task automatic test_frame_extremes();
    start_frame();
    write_reg(REG_IMAGE_WIDTH, 16'd2);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    send_pixel({8'd255, 8'd0, 8'd128});
    send_pixel({8'd0, 8'd255, 8'd128});
    send_pixel({8'd0, 8'd255, 8'd128});
    send_pixel({8'd255, 8'd0, 8'd128});
    send_pixel({8'd0, 8'd255, 8'd0});
    send_pixel({8'd255, 8'd0, 8'd255});
    send_pixel({8'd255, 8'd0, 8'd255});
    send_pixel({8'd0, 8'd255, 8'd0});
  endtask

  // Zero width and height act as one; a bit above the width field is dropped.
  task automatic test_degenerate_sizes();
    start_frame();
    write_reg(REG_IMAGE_WIDTH, 16'h2000);
    write_reg(REG_IMAGE_HEIGHT, 16'd0);
    send_pixel(rand_pixel());
    send_pixel(rand_pixel());
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_pixel({8'd200, 8'd7, 8'd255});
    send_pixel({8'd0, 8'd250, 8'd0});
    send_pixel({8'd255, 8'd0, 8'd255});
  endtask

  // Counters beyond the new size wrap at the next pixel or row end.
  task automatic test_midframe_write();
    start_frame();
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    repeat (6) send_pixel(rand_pixel());
    write_reg(REG_IMAGE_WIDTH, 16'd2);
    write_reg(REG_IMAGE_HEIGHT, 16'd1);
    repeat (4) send_pixel(rand_pixel());
  endtask

  task automatic test_backpressure();
    idling = 1'b0;
    hold_cycles = 150;
    repeat (40) send_pixel(rand_pixel());
    idling = 1'b1;
  endtask

  task automatic test_random_frames();
    int w, h, start;
    start = items_sent;
    idling = 1'b1;
    while (items_sent - start < 260) begin
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = $urandom_range(13, 300);
        2: w = $urandom_range(4090, 8191);
        default: w = $urandom_range(1, 12);
      endcase
      // A wider row below the first one would read line store entries never written.
      if (row_pos != 0 && effective_width(w) > store_filled) w = store_filled;
      case ($urandom_range(0, 9))
        0: h = 0;
        1: h = 65535;
        default: h = $urandom_range(1, 6);
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_WIDTH, {3'($urandom), 13'(w)});
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, 16'(h));
      repeat ($urandom_range(8, 48)) send_pixel(rand_pixel());
    end
  endtask

  // Width field all ones clamps to the line store size, so the row runs on
  // without an early wrap.
  task automatic test_full_width_row();
    idling = 1'b0;
    start_frame();
    write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    repeat (64) send_pixel(rand_pixel());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_red = '0;
    in_green = '0;
    in_blue = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_frame_extremes();
    test_degenerate_sizes();
    test_midframe_write();
    test_backpressure();
    test_random_frames();
    test_full_width_row();
    input_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Receiver: runs of ready, random stall bursts, and one long hold on request.
  initial begin : receiver
    int n;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_ready <= 1'b0;
      end else begin
        n = $urandom_range(1, 20);
        out_ready <= 1'b1;
      end
      repeat (n) @(negedge clk);
    end
  end

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_low_red, out_low_green, out_low_blue,
             out_high_red, out_high_green, out_high_blue};
      if (expected_results.size() == 0) begin
        flag_mismatch("item with nothing pending", -1, int'(got));
      end else begin
        want = expected_results.pop_front();
        if (got.low_red != want.low_red)
          flag_mismatch("low_red", int'(want.low_red), int'(got.low_red));
        if (got.low_green != want.low_green)
          flag_mismatch("low_green", int'(want.low_green), int'(got.low_green));
        if (got.low_blue != want.low_blue)
          flag_mismatch("low_blue", int'(want.low_blue), int'(got.low_blue));
        if (got.high_red != want.high_red)
          flag_mismatch("high_red", int'(want.high_red), int'(got.high_red));
        if (got.high_green != want.high_green)
          flag_mismatch("high_green", int'(want.high_green), int'(got.high_green));
        if (got.high_blue != want.high_blue)
          flag_mismatch("high_blue", int'(want.high_blue), int'(got.high_blue));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

[sim.f]
rtl/p2dz_pkg.sv
rtl/p2dz_line_store.sv
rtl/p2dz_diff.sv
rtl/pixel_2d_difference_zigzag.sv
tb/tb_top.sv
